FILE: hw/rtl/fsps_pkg.sv
// ----------------------------------------------------------------------------
// Frame slot pool scheduler package
// Shared types, command codes and flag positions.
// ----------------------------------------------------------------------------
package fsps_pkg;

  typedef enum logic [3:0] {
    CMD_ACQUIRE   = 4'd0,
    CMD_TAKE_CMP  = 4'd1,
    CMD_TAKE_RND  = 4'd2,
    CMD_UPLOADING = 4'd3,
    CMD_PREPARED  = 4'd4,
    CMD_COMPUTING = 4'd5,
    CMD_COMPUTED  = 4'd6,
    CMD_RENDERED  = 4'd7,
    CMD_STAMP     = 4'd8,
    CMD_QUERY     = 4'd9,
    CMD_SHUTDOWN  = 4'd10
  } cmd_e;

  localparam int unsigned FL_RSV  = 0;
  localparam int unsigned FL_UPL  = 1;
  localparam int unsigned FL_PRE  = 2;
  localparam int unsigned FL_CMP  = 3;
  localparam int unsigned FL_DONE = 4;
  localparam int unsigned FL_RND  = 5;

  localparam int unsigned REG_SKIP   = 0;
  localparam int unsigned REG_LATEST = 1;

  typedef struct packed {
    logic [3:0]  command;
    logic [2:0]  slot;
    logic [31:0] epoch;
  } item_in_t;

  typedef struct packed {
    logic       slot_valid;
    logic [2:0] slot_index;
    logic       from_fallback;
    logic       is_uploading;
    logic       is_rendering;
  } item_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic scan_last;
  } stat_t;

endpackage

FILE: hw/rtl/fsps_ctrl.sv
// ----------------------------------------------------------------------------
// Frame slot pool scheduler controller
// Sequences load, slot scan, state update and result strobe.
// ----------------------------------------------------------------------------
module fsps_ctrl import fsps_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_SCAN;
      ST_SCAN:  if (stat_i.scan_last) state_d = ST_APPLY;
      ST_APPLY: state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o      = 1'b0;
        ctrl_o.load = start_i;
      end
      ST_SCAN:  ctrl_o.scan  = 1'b1;
      ST_APPLY: ctrl_o.apply = 1'b1;
      ST_DONE:  ctrl_o.emit  = 1'b1;
      default:  busy_o = 1'b0;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.apply |=> ctrl_o.emit)
    else $error("emit must follow apply");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |=> ctrl_o.scan)
    else $error("scan must follow load");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_o.load, ctrl_o.scan, ctrl_o.apply, ctrl_o.emit}))
    else $error("controller commands overlap");

endmodule

FILE: hw/rtl/fsps_dp.sv
// ----------------------------------------------------------------------------
// Frame slot pool scheduler datapath
// Slot state, one-slot-per-cycle scan for acquire and take, state update.
// ----------------------------------------------------------------------------
module fsps_dp import fsps_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_t     ctrl_i,
  input  item_in_t  item_i,
  input  logic      skip_i,
  input  logic      latest_i,
  output stat_t     stat_o,
  output logic      res_valid_o,
  output item_out_t res_o
);

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

  logic [5:0]    flags_q [SLOT_COUNT];
  logic [31:0]   fnum_q  [SLOT_COUNT];
  logic [31:0]   epoch_q [SLOT_COUNT];
  logic [31:0]   req_q, fcnt_q;
  logic [IW-1:0] nfp_q, lri_q;
  logic          lrv_q, shut_q;

  item_in_t      item_q;
  logic [IW-1:0] off_q;
  logic          found_q, best_v_q;
  logic [IW-1:0] found_i_q, best_i_q;
  logic [31:0]   best_f_q;

  logic [IW:0]   sum;
  logic [IW-1:0] idx;
  logic [5:0]    f;
  logic          busy_f, in_range, cand, better;
  logic [IW-1:0] sidx;
  cmd_e          cmd;

  assign cmd      = cmd_e'(item_q.command);
  assign in_range = {1'b0, item_q.slot} < 4'(SLOT_COUNT);
  assign sidx     = IW'(item_q.slot);
  assign stat_o.scan_last = (off_q == LAST) || found_q;

  always_comb begin
    sum = {1'b0, nfp_q} + {1'b0, off_q};
    if (cmd != CMD_ACQUIRE) sum = {1'b0, off_q};
    if (sum >= (IW+1)'(SLOT_COUNT)) sum = sum - (IW+1)'(SLOT_COUNT);
    idx    = sum[IW-1:0];
    f      = flags_q[idx];
    busy_f = f[FL_RSV] | f[FL_UPL] | f[FL_CMP] | f[FL_RND];
    cand   = 1'b0;
    better = 1'b0;
    if (cmd == CMD_ACQUIRE) begin
      cand = !busy_f && !(SLOT_COUNT > 1 && lrv_q && idx == lri_q) &&
             (f[FL_PRE] | f[FL_DONE]) && skip_i;
      better = !best_v_q || fnum_q[idx] < best_f_q;
    end else begin
      cand = (cmd == CMD_TAKE_CMP ? f[FL_PRE] : f[FL_DONE]) && !busy_f &&
             epoch_q[idx] == req_q;
      better = !best_v_q || (latest_i ? fnum_q[idx] > best_f_q
                                      : fnum_q[idx] < best_f_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      item_q    <= item_i;
      off_q     <= '0;
      found_q   <= 1'b0;
      best_v_q  <= 1'b0;
      found_i_q <= '0;
      best_i_q  <= '0;
      best_f_q  <= '0;
    end else if (ctrl_i.scan && !found_q) begin
      if (off_q != LAST) off_q <= off_q + 1'b1;
      if (cmd == CMD_ACQUIRE && !busy_f &&
          !(SLOT_COUNT > 1 && lrv_q && idx == lri_q) &&
          !(f[FL_PRE] | f[FL_DONE])) begin
        found_q   <= 1'b1;
        found_i_q <= idx;
      end else if (cand && better) begin
        best_v_q <= 1'b1;
        best_i_q <= idx;
        best_f_q <= fnum_q[idx];
      end
    end
  end

  logic          got;
  logic [IW-1:0] gi;
  logic          fb;
  logic [IW-1:0] lr;
  logic [5:0]    lf;
  item_out_t     res_d;

  always_comb begin
    got = 1'b0;
    gi  = best_i_q;
    fb  = 1'b0;
    lr  = lri_q;
    lf  = flags_q[lri_q];
    if (!shut_q) begin
      unique case (cmd)
        CMD_ACQUIRE: begin
          got = found_q | best_v_q;
          gi  = found_q ? found_i_q : best_i_q;
        end
        CMD_TAKE_CMP: got = best_v_q;
        CMD_TAKE_RND: begin
          if (best_v_q) begin
            got = 1'b1;
          end else if (lrv_q && !(lf[FL_RND] | lf[FL_RSV] | lf[FL_UPL]) &&
                       epoch_q[lr] == req_q) begin
            got = 1'b1;
            gi  = lr;
            fb  = 1'b1;
          end
        end
        default: got = 1'b0;
      endcase
    end
    res_d               = '0;
    res_d.slot_valid    = got;
    res_d.slot_index    = got ? 3'(gi) : 3'd0;
    res_d.from_fallback = fb;
    if (cmd == CMD_QUERY && in_range) begin
      res_d.is_uploading = flags_q[sidx][FL_UPL];
      res_d.is_rendering = flags_q[sidx][FL_RND];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        flags_q[i] <= '0;
        fnum_q[i]  <= '0;
        epoch_q[i] <= '0;
      end
      req_q  <= '0;
      fcnt_q <= '0;
      nfp_q  <= '0;
      lri_q  <= '0;
      lrv_q  <= 1'b0;
      shut_q <= 1'b0;
      res_valid_o <= 1'b0;
      res_o  <= '0;
    end else begin
      res_valid_o <= ctrl_i.emit;
      if (ctrl_i.apply) begin
        res_o <= res_d;
        case (cmd)
          CMD_ACQUIRE: if (got) begin
            flags_q[gi] <= 6'b000001;
            nfp_q <= (gi == LAST) ? '0 : gi + 1'b1;
          end
          CMD_TAKE_CMP: if (got) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (IW'(i) == gi) begin
                flags_q[i][FL_CMP] <= 1'b1;
                flags_q[i][FL_PRE] <= 1'b0;
              end else if (latest_i && flags_q[i][FL_PRE] && fnum_q[i] < fnum_q[gi]) begin
                flags_q[i][FL_PRE] <= 1'b0;
              end
            end
          end
          CMD_TAKE_RND: if (got) begin
            flags_q[gi][FL_RND]  <= 1'b1;
            flags_q[gi][FL_DONE] <= 1'b0;
            lrv_q <= 1'b1;
            lri_q <= gi;
          end
          CMD_UPLOADING: if (in_range) begin
            fcnt_q <= fcnt_q + 1'b1;
            fnum_q[sidx] <= fcnt_q + 1'b1;
            flags_q[sidx][FL_RSV] <= 1'b0;
            flags_q[sidx][FL_UPL] <= 1'b1;
          end
          CMD_PREPARED: if (in_range) begin
            flags_q[sidx][FL_UPL] <= 1'b0;
            flags_q[sidx][FL_PRE] <= 1'b1;
          end
          CMD_COMPUTING: if (in_range) begin
            flags_q[sidx][FL_CMP] <= 1'b1;
            flags_q[sidx][FL_PRE] <= 1'b0;
          end
          CMD_COMPUTED: if (in_range) begin
            flags_q[sidx][FL_CMP]  <= 1'b0;
            flags_q[sidx][FL_DONE] <= 1'b1;
          end
          CMD_RENDERED: if (in_range) flags_q[sidx][FL_RND] <= 1'b0;
          CMD_STAMP: if (in_range) begin
            epoch_q[sidx] <= item_q.epoch;
            if (item_q.epoch > req_q) req_q <= item_q.epoch;
          end
          CMD_SHUTDOWN: shut_q <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(ctrl_i.emit))
    else $error("result without emit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.slot_valid |-> res_o.slot_index < 3'(SLOT_COUNT))
    else $error("slot index out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.from_fallback |-> res_o.slot_valid)
    else $error("fallback without slot");

endmodule

FILE: hw/rtl/frame_slot_pool_scheduler_core.sv
// ----------------------------------------------------------------------------
// Frame slot pool scheduler core
// Command-driven manager of a small pool of frame buffer slots.
// ----------------------------------------------------------------------------
// Usage: drive item_i and pulse start_i while busy_o is low; the item is taken
// on that edge. Every item yields one result on result_o, marked by a
// one-cycle done_o strobe; the receiver cannot stall, so results must be taken
// when shown.
// Sequencing: the scan visits one slot per cycle (stopping early when acquire
// finds an empty slot), then the apply state updates slot state and registers
// the result, and the done state raises emit, which is registered onto done_o.
// busy_o stays high from accept until the done state ends, so one item is in
// flight at a time; done_o may coincide with the next start_i accept edge only
// after busy_o falls.
// Configuration: cfg_we_i writes register cfg_idx_i (0 frame skip enable,
// 1 latest wins) at once; write only while idle.
// Reset: all slots empty, counters and epochs zero, configuration cleared,
// not shut down.
// ----------------------------------------------------------------------------
module frame_slot_pool_scheduler_core import fsps_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  item_in_t  item_i,
  output logic      done_o,
  output item_out_t result_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic      cfg_data_i
);

  ctrl_t ctrl;
  stat_t stat;
  logic  skip_q, latest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q   <= 1'b0;
      latest_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == 1'(REG_SKIP)) skip_q <= cfg_data_i;
      else latest_q <= cfg_data_i;
    end
  end

  fsps_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  fsps_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .item_i      (item_i),
    .skip_i      (skip_q),
    .latest_i    (latest_q),
    .stat_o      (stat),
    .res_valid_o (done_o),
    .res_o       (result_o)
  );

endmodule

FILE: dv/fsps_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame slot pool scheduler checker
// Watches accepted commands, configuration writes and result strobes. Keeps a
// shadow of the slot pool, predicts each result and compares it field by field
// against the oldest pending prediction.
// ----------------------------------------------------------------------------
module fsps_checker import fsps_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      busy_i,
  input  item_in_t  item_i,
  input  logic      done_i,
  input  item_out_t result_i,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic      cfg_data_i,
  output int        errors_o,
  output int        pending_o
);

  logic [5:0]  flags [SLOT_COUNT];
  logic [31:0] frame_no [SLOT_COUNT];
  logic [31:0] slot_ep [SLOT_COUNT];
  logic [31:0] req_ep, frame_cnt;
  int unsigned free_ptr, last_rnd_idx;
  logic        last_rnd_ok, is_down, skip_en, newest_en;
  item_out_t   expected_q[$];
  int          errors;

  localparam logic [5:0] BUSY_MASK = 6'b101011;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();

  task automatic report(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic int find_free();
    int oldest;
    int unsigned i;
    oldest = -1;
    for (int off = 0; off < SLOT_COUNT; off++) begin
      i = (free_ptr + off) % SLOT_COUNT;
      if ((flags[i] & BUSY_MASK) != 0) continue;
      if (SLOT_COUNT > 1 && last_rnd_ok && i == last_rnd_idx) continue;
      if (flags[i][FL_PRE] || flags[i][FL_DONE]) begin
        if (skip_en && (oldest < 0 || frame_no[i] < frame_no[oldest])) oldest = i;
        continue;
      end
      flags[i] = 6'b1 << FL_RSV;
      free_ptr = (i + 1) % SLOT_COUNT;
      return i;
    end
    if (oldest >= 0) begin
      flags[oldest] = 6'b1 << FL_RSV;
      free_ptr = (oldest + 1) % SLOT_COUNT;
    end
    return oldest;
  endfunction

  function automatic int pick_slot(input int unsigned bitpos);
    int best;
    best = -1;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!flags[i][bitpos] || (flags[i] & BUSY_MASK) != 0 || slot_ep[i] != req_ep)
        continue;
      if (best < 0 || (newest_en && frame_no[i] > frame_no[best]) ||
          (!newest_en && frame_no[i] < frame_no[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic void start_render(input int s);
    flags[s][FL_RND] = 1'b1;
    flags[s][FL_DONE] = 1'b0;
    last_rnd_ok = 1'b1;
    last_rnd_idx = s;
  endfunction

  function automatic item_out_t predict_result(input item_in_t it);
    item_out_t r;
    int got;
    int s;
    logic inr;
    r = '0;
    got = -1;
    s = it.slot;
    inr = s < SLOT_COUNT;
    case (it.command)
      CMD_ACQUIRE: if (!is_down) got = find_free();
      CMD_TAKE_CMP: if (!is_down) begin
        got = pick_slot(FL_PRE);
        if (got >= 0) begin
          if (newest_en)
            for (int i = 0; i < SLOT_COUNT; i++)
              if (i != got && flags[i][FL_PRE] && frame_no[i] < frame_no[got])
                flags[i][FL_PRE] = 1'b0;
          flags[got][FL_CMP] = 1'b1;
          flags[got][FL_PRE] = 1'b0;
        end
      end
      CMD_TAKE_RND: if (!is_down) begin
        got = pick_slot(FL_DONE);
        if (got >= 0) begin
          start_render(got);
        end else if (last_rnd_ok && last_rnd_idx < SLOT_COUNT) begin
          if (!flags[last_rnd_idx][FL_RND] && !flags[last_rnd_idx][FL_RSV] &&
              !flags[last_rnd_idx][FL_UPL] && slot_ep[last_rnd_idx] == req_ep) begin
            got = last_rnd_idx;
            start_render(got);
            r.from_fallback = 1'b1;
          end
        end
      end
      CMD_UPLOADING: if (inr) begin
        frame_cnt = frame_cnt + 1;
        frame_no[s] = frame_cnt;
        flags[s][FL_RSV] = 1'b0;
        flags[s][FL_UPL] = 1'b1;
      end
      CMD_PREPARED: if (inr) begin
        flags[s][FL_UPL] = 1'b0;
        flags[s][FL_PRE] = 1'b1;
      end
      CMD_COMPUTING: if (inr) begin
        flags[s][FL_CMP] = 1'b1;
        flags[s][FL_PRE] = 1'b0;
      end
      CMD_COMPUTED: if (inr) begin
        flags[s][FL_CMP] = 1'b0;
        flags[s][FL_DONE] = 1'b1;
      end
      CMD_RENDERED: if (inr) flags[s][FL_RND] = 1'b0;
      CMD_STAMP: if (inr) begin
        slot_ep[s] = it.epoch;
        if (it.epoch > req_ep) req_ep = it.epoch;
      end
      CMD_QUERY: if (inr) begin
        r.is_uploading = flags[s][FL_UPL];
        r.is_rendering = flags[s][FL_RND];
      end
      CMD_SHUTDOWN: is_down = 1'b1;
      default: ;
    endcase
    if (got >= 0) begin
      r.slot_valid = 1'b1;
      r.slot_index = got[2:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        flags[i] = '0;
        frame_no[i] = '0;
        slot_ep[i] = '0;
      end
      req_ep = '0;
      frame_cnt = '0;
      free_ptr = 0;
      last_rnd_idx = 0;
      last_rnd_ok = 1'b0;
      is_down = 1'b0;
      skip_en = 1'b0;
      newest_en = 1'b0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (result_i.slot_valid !== want.slot_valid)
            report("slot_valid", result_i.slot_valid, want.slot_valid);
          if (result_i.slot_index !== want.slot_index)
            report("slot_index", result_i.slot_index, want.slot_index);
          if (result_i.from_fallback !== want.from_fallback)
            report("from_fallback", result_i.from_fallback, want.from_fallback);
          if (result_i.is_uploading !== want.is_uploading)
            report("is_uploading", result_i.is_uploading, want.is_uploading);
          if (result_i.is_rendering !== want.is_rendering)
            report("is_rendering", result_i.is_rendering, want.is_rendering);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == 1'(REG_SKIP)) skip_en = cfg_data_i;
        else newest_en = cfg_data_i;
      end
      if (start_i && !busy_i) expected_q.push_back(predict_result(item_i));
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame slot pool scheduler testbench
// Drives directed and random slot lifecycle commands through several register
// settings with random sender gaps; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
  import fsps_pkg::*;

  localparam int unsigned SLOTS = 3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  item_in_t  item = '0;
  logic      done;
  item_out_t result;
  logic      cfg_we = 1'b0;
  logic      cfg_idx = 1'b0;
  logic      cfg_data = 1'b0;
  int        errors, pending;
  logic      allow_gaps = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  frame_slot_pool_scheduler_core #(.SLOT_COUNT(SLOTS)) dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .item_i(item),
    .done_o(done), .result_o(result), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  fsps_checker #(.SLOT_COUNT(SLOTS)) checker_i (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .item_i(item),
    .done_i(done), .result_i(result), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .errors_o(errors), .pending_o(pending)
  );

  task automatic send(input cmd_e c, input logic [2:0] s, input logic [31:0] ep);
    @(posedge clk);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      while (busy) @(posedge clk);
      repeat ($urandom_range(0, 4)) @(posedge clk);
    end
    start <= 1'b1;
    item <= '{command: c, slot: s, epoch: ep};
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
  endtask

  task automatic send_raw(input logic [3:0] c, input logic [2:0] s);
    @(posedge clk);
    start <= 1'b1;
    item <= '{command: c, slot: s, epoch: $urandom};
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (SLOTS + 6) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic val);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one random lifecycle step on a random slot; mostly well-formed traffic
  task automatic random_step(input logic [31:0] ep_base);
    logic [2:0] s;
    int unsigned k;
    s = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(SLOTS, 7))
                                     : 3'($urandom_range(0, SLOTS - 1));
    k = $urandom_range(0, 99);
    if (k < 14) send(CMD_ACQUIRE, s, $urandom);
    else if (k < 26) send(CMD_TAKE_CMP, s, $urandom);
    else if (k < 38) send(CMD_TAKE_RND, s, $urandom);
    else if (k < 48) send(CMD_UPLOADING, s, $urandom);
    else if (k < 58) send(CMD_PREPARED, s, $urandom);
    else if (k < 64) send(CMD_COMPUTING, s, $urandom);
    else if (k < 73) send(CMD_COMPUTED, s, $urandom);
    else if (k < 82) send(CMD_RENDERED, s, $urandom);
    else if (k < 87) send(CMD_STAMP, s, ep_base + $urandom_range(0, 1));
    else if (k < 89) send(CMD_STAMP, s, $urandom);
    else if (k < 97) send(CMD_QUERY, s, $urandom);
    else send_raw(4'($urandom_range(11, 15)), s);
  endtask

  initial begin
    logic [31:0] ep;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one full lifecycle, fallback, out-of-range and unknown codes
    send(CMD_QUERY, 3'd7, 32'hFFFF_FFFF);
    send(CMD_ACQUIRE, 3'd0, '0);
    send(CMD_UPLOADING, 3'd0, '0);
    send(CMD_QUERY, 3'd0, '0);
    send(CMD_PREPARED, 3'd0, '0);
    send(CMD_TAKE_CMP, 3'd0, '0);
    send(CMD_COMPUTING, 3'd0, '0);
    send(CMD_COMPUTED, 3'd0, '0);
    send(CMD_TAKE_RND, 3'd0, '0);
    send(CMD_QUERY, 3'd0, '0);
    send(CMD_RENDERED, 3'd0, '0);
    send(CMD_TAKE_RND, 3'd0, '0);
    send(CMD_RENDERED, 3'd0, '0);
    send(CMD_STAMP, 3'd1, 32'hFFFF_FFFF);
    send(CMD_STAMP, 3'd5, 32'h5555_5555);
    send(CMD_TAKE_RND, 3'd0, '0);
    send(CMD_UPLOADING, 3'd6, '0);
    send(CMD_PREPARED, 3'd4, '0);
    send(CMD_RENDERED, 3'd3, '0);
    send_raw(4'd11, 3'd1);
    send_raw(4'd15, 3'd2);
    send(CMD_ACQUIRE, 3'd0, '0);
    send(CMD_ACQUIRE, 3'd0, '0);
    send(CMD_ACQUIRE, 3'd0, '0);

    // random phases across every register setting; reach epoch wrap region too
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(1'(REG_SKIP), ph[0]);
      write_cfg(1'(REG_LATEST), ph[1]);
      ep = (ph == 5) ? 32'hFFFF_FFFE : 32'($urandom_range(0, 3) + ph * 4);
      for (int i = 0; i < SLOTS; i++) send(CMD_STAMP, 3'(i), ep);
      if (ph == 3) drain();
      if (ph == 7) allow_gaps = 1'b0;
      for (int n = 0; n < 125; n++) random_step(ep);
    end

    send(CMD_SHUTDOWN, 3'd0, '0);
    send(CMD_ACQUIRE, 3'd0, '0);
    send(CMD_TAKE_CMP, 3'd0, '0);
    send(CMD_TAKE_RND, 3'd0, '0);
    send(CMD_UPLOADING, 3'd1, '0);
    send(CMD_QUERY, 3'd1, '0);

    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
